// File: rtl/core/imu_bias_calibrator_macros.svh
// Assertion macros shared by the imu_bias_calibrator RTL.
// Expects signals named clock and reset in the including module.
`ifndef IMU_BIAS_CALIBRATOR_MACROS_SVH
`define IMU_BIAS_CALIBRATOR_MACROS_SVH

// same-cycle implication, off while reset is high
`define IMUBC_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define IMUBC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/imubc_pkg.sv
// Package for the IMU bias calibrator: word types, widths and codes.
// No dependencies; used by imubc_div and imu_bias_calibrator.
`default_nettype none

package imubc_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int OFS_W      = 17;
   localparam int SUM_W      = 25;
   localparam int CNT_W      = 8;
   localparam int GRAV_W     = 15;
   localparam int AXES       = 3;
   localparam int LANES      = 6;
   localparam int LANE_W     = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [GRAV_W-1:0] GRAVITY_RESET = 15'd2048;

   // register index codes (byte address / 4)
   localparam logic REG_GRAVITY = 1'b0;

   // lane numbering: acc x,y,z then gyro x,y,z
   localparam logic [LANE_W-1:0] LANE_ACC_Z    = 3'd2;
   localparam logic [LANE_W-1:0] LANE_GYRO_X   = 3'd3;
   localparam logic [LANE_W-1:0] LANE_LAST     = 3'd5;

   typedef logic signed [SAMPLE_W-1:0] imubc_sample_type;
   typedef logic signed [OFS_W-1:0]    imubc_ofs_type;
   typedef logic signed [SUM_W-1:0]    imubc_sum_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] acc_x_raw;
      logic signed [SAMPLE_W-1:0] acc_y_raw;
      logic signed [SAMPLE_W-1:0] acc_z_raw;
      logic signed [SAMPLE_W-1:0] gyro_x_raw;
      logic signed [SAMPLE_W-1:0] gyro_y_raw;
      logic signed [SAMPLE_W-1:0] gyro_z_raw;
      logic                       acc_cal_start;
      logic                       gyro_cal_start;
   } imubc_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] acc_x_fixed;
      logic signed [SAMPLE_W-1:0] acc_y_fixed;
      logic signed [SAMPLE_W-1:0] acc_z_fixed;
      logic signed [SAMPLE_W-1:0] gyro_x_fixed;
      logic signed [SAMPLE_W-1:0] gyro_y_fixed;
      logic signed [SAMPLE_W-1:0] gyro_z_fixed;
      logic                       acc_cal_done;
      logic                       gyro_cal_done;
      logic                       calibrating;
   } imubc_rsp_type;

   // finalize request from the sample stage to the divider
   typedef struct packed {
      logic start;
      logic acc;
      logic gyro;
   } imubc_div_cmd_type;

   // offset write from the divider back to the offset registers
   typedef struct packed {
      logic                    wr;
      logic [LANE_W-1:0]       lane;
      logic signed [OFS_W-1:0] data;
   } imubc_ofs_wr_type;

endpackage

`default_nettype wire

// File: rtl/core/imubc_div.sv
// Offset finalize unit: divides each lane sum by CAL_SAMPLES (toward zero).
// One lane issued per cycle through abs, reciprocal multiply, sign fix. Uses imubc_pkg.
`default_nettype none

module imubc_div #(
   parameter int CAL_SAMPLES = 250
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire imubc_pkg::imubc_div_cmd_type  cmd,
   input  wire logic [imubc_pkg::GRAV_W-1:0]  gravity,
   input  wire imubc_pkg::imubc_sum_type      sums [imubc_pkg::LANES],
   output logic                               busy,
   output imubc_pkg::imubc_ofs_wr_type        ofs_wr
);

   // |sum| <= 250 * 32768 < 2^23, so 24 magnitude bits are plenty
   localparam int MAG_W      = 24;
   localparam int SHIFT      = MAG_W + $clog2(CAL_SAMPLES);
   localparam int RECIP_W    = MAG_W + 2;
   localparam int PROD_W     = MAG_W + RECIP_W;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

   logic                                 run_ff, run_in;
   logic [imubc_pkg::LANE_W-1:0]         idx_ff, idx_in;
   logic                                 mask_acc_ff, mask_gyro_ff;
   logic [imubc_pkg::GRAV_W-1:0]         grav_ff;

   logic                                 va_ff, va_in;
   logic [imubc_pkg::LANE_W-1:0]         lane_a_ff;
   logic                                 neg_a_ff;
   logic [MAG_W-1:0]                     mag_ff, mag_in;

   logic                                 vb_ff;
   logic [imubc_pkg::LANE_W-1:0]         lane_b_ff;
   logic                                 neg_b_ff;
   logic [imubc_pkg::OFS_W-1:0]          quo_ff, quo_in;

   imubc_pkg::imubc_sum_type             sum_sel;
   imubc_pkg::imubc_sum_type             sum_abs;
   logic [PROD_W-1:0]                    prod;
   logic [imubc_pkg::OFS_W-1:0]          quo_signed;
   logic [imubc_pkg::OFS_W-1:0]          zsub;
   logic                                 lane_is_gyro;

   // issue stage: one lane per cycle
   always_comb begin
      run_in = run_ff;
      idx_in = idx_ff;
      if (cmd.start) begin
         run_in = 1'b1;
         idx_in = '0;
      end else if (run_ff) begin
         idx_in = idx_ff + 1'b1;
         if (idx_ff == imubc_pkg::LANE_LAST) begin
            run_in = 1'b0;
         end
      end
   end

   assign sum_sel = sums[idx_ff];
   assign sum_abs = sum_sel[imubc_pkg::SUM_W-1] ? -sum_sel : sum_sel;
   assign mag_in  = sum_abs[MAG_W-1:0];
   assign va_in   = run_ff;

   // exact floor(mag / CAL_SAMPLES) by reciprocal
   assign prod   = PROD_W'(mag_ff) * PROD_W'(RECIP);
   assign quo_in = prod[SHIFT +: imubc_pkg::OFS_W];

   // write stage
   assign quo_signed   = neg_b_ff ? -quo_ff : quo_ff;
   assign zsub         = (lane_b_ff == imubc_pkg::LANE_ACC_Z) ?
                         {{(imubc_pkg::OFS_W-imubc_pkg::GRAV_W){1'b0}}, grav_ff} : '0;
   assign lane_is_gyro = (lane_b_ff >= imubc_pkg::LANE_GYRO_X);

   always_comb begin
      ofs_wr.wr   = vb_ff && (lane_is_gyro ? mask_gyro_ff : mask_acc_ff);
      ofs_wr.lane = lane_b_ff;
      ofs_wr.data = quo_signed - zsub;
   end

   assign busy = run_ff | va_ff | vb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         va_ff  <= 1'b0;
         vb_ff  <= 1'b0;
      end else begin
         run_ff <= run_in;
         va_ff  <= va_in;
         vb_ff  <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      lane_a_ff <= idx_ff;
      neg_a_ff  <= sum_sel[imubc_pkg::SUM_W-1];
      mag_ff    <= mag_in;
      lane_b_ff <= lane_a_ff;
      neg_b_ff  <= neg_a_ff;
      quo_ff    <= quo_in;
      if (cmd.start) begin
         mask_acc_ff  <= cmd.acc;
         mask_gyro_ff <= cmd.gyro;
         grav_ff      <= gravity;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/imu_bias_calibrator.sv
// IMU bias calibrator top: offset removal, calibration sums, CSR port.
// Depends on imubc_pkg, imubc_div and imu_bias_calibrator_macros.svh.
//
//   channel   dir   handshake                       word
//   req       in    req_valid / req_ready           imubc_req_type
//   rsp       out   rsp_valid / rsp_ready           imubc_rsp_type
//   csr       in    csr_psel/penable, pready = 1    gravity_counts at 0x0
//
// One word per cycle if not held: input register, subtract/accumulate, result register.
// rsp_valid is registered: it rises on the edge that loads the result register.
// A word that finalizes a calibration starts the divider, which holds off the next
// word until its 6 lanes pass issue, multiply and write. rsp backpressure stalls the
// input register; synchronous reset clears flags, counts, sums and offsets.
`default_nettype none
`include "imu_bias_calibrator_macros.svh"

module imu_bias_calibrator #(
   parameter int CAL_SAMPLES = 250
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire imubc_pkg::imubc_req_type          req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output imubc_pkg::imubc_rsp_type               rsp_data,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [imubc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [imubc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [imubc_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                   csr_pready
);

   localparam logic [imubc_pkg::CNT_W-1:0] FIN_COUNT = imubc_pkg::CNT_W'(CAL_SAMPLES + 1);

   logic                               in_valid_ff;
   imubc_pkg::imubc_req_type           in_data_ff;
   logic                               rsp_valid_ff;
   imubc_pkg::imubc_rsp_type           rsp_data_ff, rsp_data_in;
   logic [imubc_pkg::GRAV_W-1:0]       gravity_ff;

   imubc_pkg::imubc_ofs_type           ofs_ff [imubc_pkg::LANES];
   imubc_pkg::imubc_ofs_type           ofs_in [imubc_pkg::LANES];
   imubc_pkg::imubc_sum_type           sums_ff [imubc_pkg::LANES];
   imubc_pkg::imubc_sum_type           sums_in [imubc_pkg::LANES];
   logic [imubc_pkg::CNT_W-1:0]        cnt_ff [2];
   logic [imubc_pkg::CNT_W-1:0]        cnt_in [2];
   logic [1:0]                         active_ff, active_in;

   imubc_pkg::imubc_sample_type        raw [imubc_pkg::LANES];
   imubc_pkg::imubc_sample_type        fixed [imubc_pkg::LANES];
   logic [1:0]                         act;
   logic [1:0]                         fin;
   logic                               advance;
   logic                               csr_wr;

   imubc_pkg::imubc_div_cmd_type       div_cmd;
   imubc_pkg::imubc_ofs_wr_type        ofs_wr;
   logic                               div_busy;

   // handshake
   assign advance   = in_valid_ff && !div_busy && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign raw[0] = in_data_ff.acc_x_raw;
   assign raw[1] = in_data_ff.acc_y_raw;
   assign raw[2] = in_data_ff.acc_z_raw;
   assign raw[3] = in_data_ff.gyro_x_raw;
   assign raw[4] = in_data_ff.gyro_y_raw;
   assign raw[5] = in_data_ff.gyro_z_raw;

   // wrap to 16 bits: only the low offset bits matter
   always_comb begin
      for (int k = 0; k < imubc_pkg::LANES; k++) begin
         fixed[k] = raw[k] - ofs_ff[k][imubc_pkg::SAMPLE_W-1:0];
      end
   end

   assign act[0] = active_ff[0] | in_data_ff.acc_cal_start;
   assign act[1] = active_ff[1] | in_data_ff.gyro_cal_start;

   // sensor 0 = acc, 1 = gyro; an acc clear word skips gyro work
   always_comb begin
      logic skip;
      logic [imubc_pkg::CNT_W-1:0] cnt_next;
      skip      = 1'b0;
      cnt_next  = '0;
      fin       = '0;
      active_in = act;
      for (int k = 0; k < imubc_pkg::LANES; k++) begin
         ofs_in[k]  = ofs_ff[k];
         sums_in[k] = sums_ff[k];
      end
      for (int s = 0; s < 2; s++) begin
         cnt_in[s] = cnt_ff[s];
      end
      for (int s = 0; s < 2; s++) begin
         if (act[s] && !skip) begin
            if (cnt_ff[s] == '0) begin
               for (int a = 0; a < imubc_pkg::AXES; a++) begin
                  ofs_in[s*imubc_pkg::AXES + a]  = '0;
                  sums_in[s*imubc_pkg::AXES + a] = '0;
               end
               cnt_in[s] = imubc_pkg::CNT_W'(1);
               skip      = 1'b1;
            end else begin
               cnt_next  = cnt_ff[s] + 1'b1;
               cnt_in[s] = cnt_next;
               for (int a = 0; a < imubc_pkg::AXES; a++) begin
                  sums_in[s*imubc_pkg::AXES + a] = sums_ff[s*imubc_pkg::AXES + a] +
                     {{(imubc_pkg::SUM_W-imubc_pkg::SAMPLE_W)
                       {fixed[s*imubc_pkg::AXES + a][imubc_pkg::SAMPLE_W-1]}},
                      fixed[s*imubc_pkg::AXES + a]};
               end
               if (cnt_next == FIN_COUNT) begin
                  cnt_in[s]    = '0;
                  active_in[s] = 1'b0;
                  fin[s]       = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      rsp_data_in.acc_x_fixed  = fixed[0];
      rsp_data_in.acc_y_fixed  = fixed[1];
      rsp_data_in.acc_z_fixed  = fixed[2];
      rsp_data_in.gyro_x_fixed = fixed[3];
      rsp_data_in.gyro_y_fixed = fixed[4];
      rsp_data_in.gyro_z_fixed = fixed[5];
      rsp_data_in.acc_cal_done  = fin[0];
      rsp_data_in.gyro_cal_done = fin[1];
      rsp_data_in.calibrating   = act[0] | act[1];
   end

   always_comb begin
      div_cmd.start = advance && (fin != '0);
      div_cmd.acc   = fin[0];
      div_cmd.gyro  = fin[1];
   end

   imubc_div #(
      .CAL_SAMPLES (CAL_SAMPLES)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .cmd     (div_cmd),
      .gravity (gravity_ff),
      .sums    (sums_ff),
      .busy    (div_busy),
      .ofs_wr  (ofs_wr)
   );

   // CSR port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[2])
         imubc_pkg::REG_GRAVITY: begin
            csr_prdata = {{(imubc_pkg::CSR_DATA_W-imubc_pkg::GRAV_W){1'b0}}, gravity_ff};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gravity_ff   <= imubc_pkg::GRAVITY_RESET;
         active_ff    <= '0;
         for (int s = 0; s < 2; s++) begin
            cnt_ff[s] <= '0;
         end
         for (int k = 0; k < imubc_pkg::LANES; k++) begin
            ofs_ff[k]  <= '0;
            sums_ff[k] <= '0;
         end
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr && (csr_paddr[2] == imubc_pkg::REG_GRAVITY)) begin
            gravity_ff <= csr_pwdata[imubc_pkg::GRAV_W-1:0];
         end
         if (advance) begin
            active_ff <= active_in;
            for (int s = 0; s < 2; s++) begin
               cnt_ff[s] <= cnt_in[s];
            end
            for (int k = 0; k < imubc_pkg::LANES; k++) begin
               ofs_ff[k]  <= ofs_in[k];
               sums_ff[k] <= sums_in[k];
            end
         end else if (ofs_wr.wr) begin
            ofs_ff[ofs_wr.lane] <= ofs_wr.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `IMUBC_ASSERT(a_hold_while_div, div_busy, !advance, "word advanced while divider busy")
   `IMUBC_ASSERT_NEXT(a_div_after_fin, advance && (fin != '0), div_busy, "divider not started")
   `IMUBC_ASSERT(a_acc_idle_count, !active_ff[0], cnt_ff[0] == '0, "acc count nonzero while idle")
   `IMUBC_ASSERT(a_gyro_idle_count, !active_ff[1], cnt_ff[1] == '0, "gyro count nonzero while idle")

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking bench for imu_bias_calibrator: drives sample words, checks corrected
// words and calibration flags against a cycle-free model of offsets, sums and counts.
// Depends on imubc_pkg and the imu_bias_calibrator RTL only.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAL_LEN        = 250;
   localparam int SENS_ACC       = 0;
   localparam int SENS_GYRO      = 1;
   localparam int DIVIDER_SETTLE = 16;
   localparam int LONG_HOLD      = 80;
   localparam int PRINT_CAP      = 40;
   localparam logic [imubc_pkg::CSR_ADDR_W-1:0] GRAVITY_ADDR = {imubc_pkg::REG_GRAVITY, 2'b00};

   typedef enum int {RX_OPEN, RX_RANDOM, RX_ONE_IN_THREE} rx_mode_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   imubc_pkg::imubc_req_type            req_data = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   imubc_pkg::imubc_rsp_type            rsp_data;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [imubc_pkg::CSR_ADDR_W-1:0]    csr_paddr = '0;
   logic [imubc_pkg::CSR_DATA_W-1:0]    csr_pwdata = '0;
   logic [imubc_pkg::CSR_DATA_W-1:0]    csr_prdata;
   logic                                csr_pready;

   imu_bias_calibrator #(.CAL_SAMPLES(CAL_LEN)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // offset/calibration model state, index 0 = accel, 1 = gyro
   int bias[2][3];
   int accum[2][3];
   int corr[2][3];
   int cal_cnt[2];
   bit cal_run[2];
   int gravity_level = imubc_pkg::GRAVITY_RESET;

   imubc_pkg::imubc_rsp_type pending_corrected[$];

   int bad_field_count = 0;
   int words_sent = 0;
   int words_checked = 0;
   int acc_done_seen = 0;
   int gyro_done_seen = 0;
   int gravity_writes = 0;
   int burst_left = 0;
   int axis_level[6];

   // receiver-owned stall state; tests only bump hold_asked
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;
   int mode_left = 0;
   int rx_phase = 0;
   rx_mode_type rx_mode = RX_OPEN;

   // one calibration step; returns 1 on a clear step, which skips the rest of the word
   function automatic bit calib_step(int s, int zsub, output bit done);
      done = 1'b0;
      if (cal_cnt[s] == 0) begin
         for (int i = 0; i < 3; i++) begin
            bias[s][i]  = 0;
            accum[s][i] = 0;
         end
         cal_cnt[s] = 1;
         return 1'b1;
      end
      cal_cnt[s] = (cal_cnt[s] + 1) & 8'hFF;
      for (int i = 0; i < 3; i++)
         accum[s][i] += corr[s][i];
      if (cal_cnt[s] == CAL_LEN + 1) begin
         // SV integer division truncates toward zero
         for (int i = 0; i < 3; i++)
            bias[s][i] = accum[s][i] / CAL_LEN;
         bias[s][2] -= zsub;
         cal_cnt[s] = 0;
         cal_run[s] = 1'b0;
         done = 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic imubc_pkg::imubc_rsp_type corrected_sample(imubc_pkg::imubc_req_type w);
      imubc_pkg::imubc_rsp_type    r;
      imubc_pkg::imubc_sample_type t;
      int                          rawv[2][3];
      bit                          skip;
      bit                          done_a;
      bit                          done_g;
      rawv[SENS_ACC][0]  = w.acc_x_raw;
      rawv[SENS_ACC][1]  = w.acc_y_raw;
      rawv[SENS_ACC][2]  = w.acc_z_raw;
      rawv[SENS_GYRO][0] = w.gyro_x_raw;
      rawv[SENS_GYRO][1] = w.gyro_y_raw;
      rawv[SENS_GYRO][2] = w.gyro_z_raw;
      for (int s = 0; s < 2; s++)
         for (int i = 0; i < 3; i++) begin
            t = imubc_pkg::imubc_sample_type'(rawv[s][i] - bias[s][i]);
            corr[s][i] = t;
         end
      r.acc_x_fixed  = imubc_pkg::imubc_sample_type'(corr[SENS_ACC][0]);
      r.acc_y_fixed  = imubc_pkg::imubc_sample_type'(corr[SENS_ACC][1]);
      r.acc_z_fixed  = imubc_pkg::imubc_sample_type'(corr[SENS_ACC][2]);
      r.gyro_x_fixed = imubc_pkg::imubc_sample_type'(corr[SENS_GYRO][0]);
      r.gyro_y_fixed = imubc_pkg::imubc_sample_type'(corr[SENS_GYRO][1]);
      r.gyro_z_fixed = imubc_pkg::imubc_sample_type'(corr[SENS_GYRO][2]);
      if (w.acc_cal_start)
         cal_run[SENS_ACC] = 1'b1;
      if (w.gyro_cal_start)
         cal_run[SENS_GYRO] = 1'b1;
      r.calibrating = cal_run[SENS_ACC] || cal_run[SENS_GYRO];
      skip   = 1'b0;
      done_a = 1'b0;
      done_g = 1'b0;
      if (cal_run[SENS_ACC])
         skip = calib_step(SENS_ACC, gravity_level, done_a);
      if (!skip && cal_run[SENS_GYRO])
         void'(calib_step(SENS_GYRO, 0, done_g));
      r.acc_cal_done  = done_a;
      r.gyro_cal_done = done_g;
      return r;
   endfunction

   task automatic report_bad_field(string what, int got, int want);
      if (bad_field_count < PRINT_CAP)
         $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
      bad_field_count++;
   endtask

   task automatic compare_word(imubc_pkg::imubc_rsp_type got, imubc_pkg::imubc_rsp_type want);
      if (got.acc_x_fixed !== want.acc_x_fixed)
         report_bad_field("acc_x_fixed", got.acc_x_fixed, want.acc_x_fixed);
      if (got.acc_y_fixed !== want.acc_y_fixed)
         report_bad_field("acc_y_fixed", got.acc_y_fixed, want.acc_y_fixed);
      if (got.acc_z_fixed !== want.acc_z_fixed)
         report_bad_field("acc_z_fixed", got.acc_z_fixed, want.acc_z_fixed);
      if (got.gyro_x_fixed !== want.gyro_x_fixed)
         report_bad_field("gyro_x_fixed", got.gyro_x_fixed, want.gyro_x_fixed);
      if (got.gyro_y_fixed !== want.gyro_y_fixed)
         report_bad_field("gyro_y_fixed", got.gyro_y_fixed, want.gyro_y_fixed);
      if (got.gyro_z_fixed !== want.gyro_z_fixed)
         report_bad_field("gyro_z_fixed", got.gyro_z_fixed, want.gyro_z_fixed);
      if (got.acc_cal_done !== want.acc_cal_done)
         report_bad_field("acc_cal_done", got.acc_cal_done, want.acc_cal_done);
      if (got.gyro_cal_done !== want.gyro_cal_done)
         report_bad_field("gyro_cal_done", got.gyro_cal_done, want.gyro_cal_done);
      if (got.calibrating !== want.calibrating)
         report_bad_field("calibrating", got.calibrating, want.calibrating);
   endtask

   always @(posedge clock) begin : check_words
      imubc_pkg::imubc_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_corrected.size() == 0) begin
            report_bad_field("word with nothing pending", 0, 0);
         end else begin
            want = pending_corrected.pop_front();
            compare_word(rsp_data, want);
            words_checked++;
            if (want.acc_cal_done)
               acc_done_seen++;
            if (want.gyro_cal_done)
               gyro_done_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = LONG_HOLD;
         end
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 100);
         end
         mode_left--;
         rx_phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
               default:   rsp_ready <= (rx_phase % 3 == 0);
            endcase
         end
      end
   end

   task automatic send_word(imubc_pkg::imubc_req_type w);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!(req_valid && req_ready));
      pending_corrected.push_back(corrected_sample(w));
      words_sent++;
   endtask

   // drain, then give the divider time to write back offsets
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (pending_corrected.size() != 0) @(posedge clock);
      repeat (DIVIDER_SETTLE) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic csr_access(bit wr, logic [imubc_pkg::CSR_ADDR_W-1:0] addr,
                             logic [imubc_pkg::CSR_DATA_W-1:0] wdata,
                             output logic [imubc_pkg::CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic imubc_pkg::imubc_req_type flat_word(logic [imubc_pkg::SAMPLE_W-1:0] v,
                                                           bit sa, bit sg);
      imubc_pkg::imubc_req_type w;
      w.acc_x_raw      = v;
      w.acc_y_raw      = v;
      w.acc_z_raw      = v;
      w.gyro_x_raw     = v;
      w.gyro_y_raw     = v;
      w.gyro_z_raw     = v;
      w.acc_cal_start  = sa;
      w.gyro_cal_start = sg;
      return w;
   endfunction

   // mostly a steady sensor with noise, now and then a full-range reading
   function automatic imubc_pkg::imubc_req_type random_reading(int start_odds);
      imubc_pkg::imubc_req_type w;
      int                       v[6];
      for (int i = 0; i < 6; i++) begin
         if ($urandom_range(0, 7) == 0)
            v[i] = $urandom;
         else
            v[i] = axis_level[i] + $urandom_range(0, 512) - 256;
      end
      w.acc_x_raw      = imubc_pkg::imubc_sample_type'(v[0]);
      w.acc_y_raw      = imubc_pkg::imubc_sample_type'(v[1]);
      w.acc_z_raw      = imubc_pkg::imubc_sample_type'(v[2]);
      w.gyro_x_raw     = imubc_pkg::imubc_sample_type'(v[3]);
      w.gyro_y_raw     = imubc_pkg::imubc_sample_type'(v[4]);
      w.gyro_z_raw     = imubc_pkg::imubc_sample_type'(v[5]);
      w.acc_cal_start  = ($urandom_range(1, start_odds) == 1);
      w.gyro_cal_start = ($urandom_range(1, start_odds) == 1);
      return w;
   endfunction

   task automatic test_csr_reset_value();
      logic [imubc_pkg::CSR_DATA_W-1:0] rd;
      csr_access(1'b0, GRAVITY_ADDR, '0, rd);
      if (rd !== imubc_pkg::CSR_DATA_W'(imubc_pkg::GRAVITY_RESET))
         report_bad_field("gravity_counts after reset", rd, imubc_pkg::GRAVITY_RESET);
   endtask

   task automatic test_extreme_samples();
      send_word(flat_word(16'h8000, 1'b0, 1'b0));
      send_word(flat_word(16'h7FFF, 1'b0, 1'b0));
      send_word(flat_word(16'h5555, 1'b0, 1'b0));
      send_word(flat_word(16'hAAAA, 1'b0, 1'b0));
      send_word(flat_word(16'hFFFF, 1'b0, 1'b0));
   endtask

   task automatic test_calibration_corner_cases();
      // gyro alone starts and clears
      send_word(flat_word(16'h0123, 1'b0, 1'b1));
      for (int k = 0; k < 3; k++)
         send_word(flat_word(16'(k * 700 - 900), 1'b0, 1'b0));
      // accel start while gyro runs: the accel clear word skips gyro work
      send_word(flat_word(16'h0400, 1'b1, 1'b0));
      // starts while both are running are ignored
      send_word(flat_word(16'hFC00, 1'b1, 1'b1));
      send_word(flat_word(16'h0010, 1'b1, 1'b0));
      send_word(flat_word(16'h0020, 1'b0, 1'b1));
      // full-scale words go into the sums
      send_word(flat_word(16'h7FFF, 1'b0, 1'b0));
      send_word(flat_word(16'h8000, 1'b0, 1'b0));
      send_word(flat_word(16'h8000, 1'b0, 1'b0));
      send_word(flat_word(16'h0000, 1'b0, 1'b0));
      send_word(flat_word(16'hFFFF, 1'b0, 1'b0));
   endtask

   // kick: both starts on the first word, so the gyro start lands on an accel clear word
   task automatic test_calibration_run(logic [imubc_pkg::GRAV_W-1:0] grav, int n, bit kick);
      logic [imubc_pkg::CSR_DATA_W-1:0] rd;
      imubc_pkg::imubc_req_type         w;
      settle_idle();
      csr_access(1'b1, GRAVITY_ADDR, imubc_pkg::CSR_DATA_W'(grav), rd);
      gravity_level = grav;
      gravity_writes++;
      csr_access(1'b0, GRAVITY_ADDR, '0, rd);
      if (rd !== imubc_pkg::CSR_DATA_W'(grav))
         report_bad_field("gravity_counts readback", rd, grav);
      for (int i = 0; i < 6; i++)
         axis_level[i] = $urandom_range(0, 8000) - 4000;
      axis_level[2] += grav;
      for (int k = 0; k < n; k++) begin
         w = random_reading(150);
         if (kick && k == 0) begin
            w.acc_cal_start  = 1'b1;
            w.gyro_cal_start = 1'b1;
         end
         send_word(w);
      end
   endtask

   // receiver holds off for a long stretch while words keep coming
   task automatic test_output_backpressure();
      hold_asked++;
      for (int k = 0; k < 40; k++)
         send_word(random_reading(100));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_csr_reset_value();
      test_extreme_samples();
      test_calibration_corner_cases();
      test_calibration_run(imubc_pkg::GRAVITY_RESET, 245, 1'b0);
      test_output_backpressure();
      test_calibration_run(15'h7FFF, 255, 1'b1);
      settle_idle();
      $display("Sent %0d sample words over %0d gravity settings, %0d results checked.",
               words_sent, gravity_writes, words_checked);
      $display("Saw %0d accel and %0d gyro calibrations finish; one %0d-cycle output stall.",
               acc_done_seen, gyro_done_seen, LONG_HOLD);
      if (bad_field_count == 0 && pending_corrected.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d words outstanding.", pending_corrected.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/imubc_pkg.sv
rtl/core/imubc_div.sv
rtl/core/imu_bias_calibrator.sv
verif/testbench.sv
